FILE: src/tamcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tamcd_pkg
// Types and constants shared by the motion change detector modules.
// ----------------------------------------------------------------------------
package tamcd_pkg;

  localparam int unsigned WORD_W    = 16;
  localparam int unsigned COUNT_W   = 12;
  localparam int unsigned HOLDOFF_W = 8;
  localparam int unsigned EVENT_W   = 2;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 12;

  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned OUT_TUSER_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF   = 1'd1;

  localparam logic [COUNT_W-1:0]   THRESHOLD_RST = 12'd308;  // 0.3 g, rounded up
  localparam logic [HOLDOFF_W-1:0] HOLDOFF_RST   = 8'd30;

  // event codes
  localparam logic [EVENT_W-1:0] EV_NONE = 2'd0;
  localparam logic [EVENT_W-1:0] EV_X    = 2'd1;
  localparam logic [EVENT_W-1:0] EV_Y    = 2'd2;
  localparam logic [EVENT_W-1:0] EV_Z    = 2'd3;

  typedef struct packed {
    logic [COUNT_W-1:0]   threshold;
    logic [HOLDOFF_W-1:0] holdoff;
  } cfg_t;

  // x_word in the low bits, z_word in the high bits, as on the stream
  typedef struct packed {
    logic [WORD_W-1:0] z_word;
    logic [WORD_W-1:0] y_word;
    logic [WORD_W-1:0] x_word;
  } sample_t;

  typedef struct packed {
    logic signed [COUNT_W-1:0] z_count;
    logic signed [COUNT_W-1:0] y_count;
    logic signed [COUNT_W-1:0] x_count;
  } counts_t;

  typedef struct packed {
    logic               sample_accepted;
    logic [EVENT_W-1:0] event_code;
    counts_t            counts;
  } result_t;

  // count sits left justified, low nibble is don't-care
  function automatic logic signed [COUNT_W-1:0] word_to_count(input logic [WORD_W-1:0] w);
    return w[WORD_W-1 -: COUNT_W];
  endfunction

  function automatic logic changed(input logic signed [COUNT_W-1:0] now_c,
                                   input logic signed [COUNT_W-1:0] prev_c,
                                   input logic [COUNT_W-1:0]        thr);
    logic signed [COUNT_W:0] d;
    logic [COUNT_W:0]        mag;
    d   = {now_c[COUNT_W-1], now_c} - {prev_c[COUNT_W-1], prev_c};
    mag = d[COUNT_W] ? (~d + 1'b1) : d;
    return mag >= {1'b0, thr};
  endfunction

endpackage

FILE: src/three_axis_motion_change_detector_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_axis_motion_change_detector_top
// Accelerometer transient detector: flags the first axis whose change since
// the last accepted sample reaches the threshold, then holds off.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one sample per word: tdata = x, y, z raw 16-bit words.
//   m_axis returns one word per sample: tdata = x, y, z 12-bit counts,
//   tuser = event code and the sample-accepted flag.
//   cfg_* writes the threshold (index 0) and holdoff length (index 1);
//   write only while no sample is in flight.
// Timing:
//   A sample accepted into the input register is evaluated and lands in the
//   result register when the result slot is free or being drained, and
//   m_axis_tvalid rises with it. One sample per cycle is sustained while the
//   receiver keeps tready high; the compare against the stored counts and the
//   holdoff update both happen in the same evaluate cycle.
//   When the receiver stalls, the result register holds and the input
//   register keeps one more sample; tready drops once both are full.
// Reset:
//   Clears both stages, the stored counts, the primed flag and the holdoff
//   counter; registers return to threshold 308 and holdoff 30.
// ----------------------------------------------------------------------------
module three_axis_motion_change_detector_top
  import tamcd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // config write port
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  // sample stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // x_word[15:0], y_word[31:16], z_word[47:32]
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // x_count[11:0], y_count[23:12],
                                                // z_count[35:24], zero fill [39:36]
  output logic [OUT_TUSER_W-1:0] m_axis_tuser   // event_code[1:0], sample_accepted[2]
);

  cfg_t    cfg;
  sample_t in_q;
  logic    in_vld_q;
  result_t res_q, res;
  logic    res_vld_q;
  logic    fire;
  logic    take;

  tamcd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  tamcd_eval u_eval (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .fire_i   (fire),
    .sample_i (in_q),
    .result_o (res)
  );

  // evaluate when the result slot is free or being drained
  assign fire          = in_vld_q && (!res_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || fire;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (take) begin
        in_vld_q <= 1'b1;
      end else if (fire) begin
        in_vld_q <= 1'b0;
      end
      if (fire) begin
        res_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) in_q  <= sample_t'(s_axis_tdata);
    if (fire) res_q <= res;
  end

  assign m_axis_tvalid = res_vld_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - $bits(counts_t)){1'b0}}, res_q.counts};
  assign m_axis_tuser  = {res_q.sample_accepted, res_q.event_code};

endmodule

FILE: src/tamcd_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tamcd_cfg_regs
// Threshold and holdoff registers behind a plain write port.
// ----------------------------------------------------------------------------
module tamcd_cfg_regs
  import tamcd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_THRESHOLD: cfg_d.threshold = cfg_wdata_i[COUNT_W-1:0];
        REG_HOLDOFF:   cfg_d.holdoff   = cfg_wdata_i[HOLDOFF_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= THRESHOLD_RST;
      cfg_q.holdoff   <= HOLDOFF_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/tamcd_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tamcd_eval
// Converts one sample, compares it with the stored sample and keeps the
// detector state (stored counts, primed flag, holdoff counter).
// ----------------------------------------------------------------------------
module tamcd_eval
  import tamcd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    fire_i,     // sample moves to the result register this cycle
  input  sample_t sample_i,
  output result_t result_o
);

  counts_t              prev_q, prev_d;
  logic                 primed_q, primed_d;
  logic [HOLDOFF_W-1:0] holdoff_q, holdoff_d;

  counts_t              cur;
  logic [EVENT_W-1:0]   code;
  logic                 accepted;

  always_comb begin
    cur.x_count = word_to_count(sample_i.x_word);
    cur.y_count = word_to_count(sample_i.y_word);
    cur.z_count = word_to_count(sample_i.z_word);

    code      = EV_NONE;
    accepted  = 1'b0;
    prev_d    = prev_q;
    primed_d  = primed_q;
    holdoff_d = holdoff_q;

    if (holdoff_q != '0) begin
      holdoff_d = holdoff_q - 1'b1;
    end else begin
      accepted = 1'b1;
      prev_d   = cur;
      primed_d = 1'b1;
      if (primed_q) begin
        priority if (changed(cur.x_count, prev_q.x_count, cfg_i.threshold)) begin
          code = EV_X;
        end else if (changed(cur.y_count, prev_q.y_count, cfg_i.threshold)) begin
          code = EV_Y;
        end else if (changed(cur.z_count, prev_q.z_count, cfg_i.threshold)) begin
          code = EV_Z;
        end else begin
          code = EV_NONE;
        end
        if (code != EV_NONE) holdoff_d = cfg_i.holdoff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      primed_q  <= 1'b0;
      holdoff_q <= '0;
    end else if (fire_i) begin
      prev_q    <= prev_d;
      primed_q  <= primed_d;
      holdoff_q <= holdoff_d;
    end
  end

  assign result_o.sample_accepted = accepted;
  assign result_o.event_code      = code;
  assign result_o.counts          = cur;

endmodule

FILE: verif/three_axis_motion_change_detector_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_axis_motion_change_detector_top_test
// Self-checking bench for the motion change detector. A scoreboard class
// predicts one result word per accepted sample and compares it with what
// comes out. Directed samples first, then random phases with new register
// settings, bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module three_axis_motion_change_detector_top_test;
  import tamcd_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;

  typedef struct {
    logic [EVENT_W-1:0] event_code;
    logic               accepted;
    logic [COUNT_W-1:0] x_count;
    logic [COUNT_W-1:0] y_count;
    logic [COUNT_W-1:0] z_count;
  } motion_result_t;

  class motion_scoreboard;
    logic [COUNT_W-1:0]   threshold;
    logic [HOLDOFF_W-1:0] holdoff;
    int                   last_x;
    int                   last_y;
    int                   last_z;
    bit                   primed;
    int unsigned          holdoff_left;
    motion_result_t       expected_q[$];
    int unsigned          errors;

    function new();
      threshold    = THRESHOLD_RST;
      holdoff      = HOLDOFF_RST;
      last_x       = 0;
      last_y       = 0;
      last_z       = 0;
      primed       = 1'b0;
      holdoff_left = 0;
      errors       = 0;
    endfunction

    function void set_config(logic [COUNT_W-1:0] thr, logic [HOLDOFF_W-1:0] hold);
      threshold = thr;
      holdoff   = hold;
    endfunction

    // bits 15..4 carry the signed count
    function int to_count(logic [WORD_W-1:0] w);
      int bits;
      bits = int'(w >> 4) & 32'hFFF;
      return (bits >= 2048) ? bits - 4096 : bits;
    endfunction

    function bit moved(int now_c, int prev_c);
      int d;
      d = now_c - prev_c;
      if (d < 0) d = -d;
      return d >= int'(threshold);
    endfunction

    function void note_sample(logic [IN_TDATA_W-1:0] raw);
      sample_t        s;
      motion_result_t r;
      int             x;
      int             y;
      int             z;
      s = raw;
      x = to_count(s.x_word);
      y = to_count(s.y_word);
      z = to_count(s.z_word);
      r.event_code = EV_NONE;
      r.accepted   = 1'b0;
      r.x_count    = x[COUNT_W-1:0];
      r.y_count    = y[COUNT_W-1:0];
      r.z_count    = z[COUNT_W-1:0];
      if (holdoff_left != 0) begin
        holdoff_left--;
      end else begin
        r.accepted = 1'b1;
        if (primed) begin
          if (moved(x, last_x)) r.event_code = EV_X;
          else if (moved(y, last_y)) r.event_code = EV_Y;
          else if (moved(z, last_z)) r.event_code = EV_Z;
          if (r.event_code != EV_NONE) holdoff_left = holdoff;
        end else begin
          primed = 1'b1;
        end
        last_x = x;
        last_y = y;
        last_z = z;
      end
      expected_q.push_back(r);
    endfunction

    function void compare(string field, logic [COUNT_W-1:0] exp_v,
                          logic [COUNT_W-1:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, field, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] data,
                               logic [OUT_TUSER_W-1:0] user);
      motion_result_t r;
      if (expected_q.size() == 0) begin
        $display("%0t: result word with none expected: expected nothing, actual %h/%h",
                 $time, data, user);
        errors++;
        return;
      end
      r = expected_q.pop_front();
      compare("event_code", COUNT_W'(r.event_code), COUNT_W'(user[1:0]));
      compare("sample_accepted", COUNT_W'(r.accepted), COUNT_W'(user[2]));
      compare("x_count", r.x_count, data[11:0]);
      compare("y_count", r.y_count, data[23:12]);
      compare("z_count", r.z_count, data[35:24]);
      compare("zero fill", '0, COUNT_W'(data[39:36]));
    endfunction
  endclass

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_addr_i    = REG_THRESHOLD;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // x_word, y_word, z_word
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b1;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // x_count, y_count, z_count, zero fill
  logic [OUT_TUSER_W-1:0] m_axis_tuser;        // event_code, sample_accepted

  motion_scoreboard sb;
  int unsigned      burst_left  = 0;
  int unsigned      idle_cycles = 0;
  bit               no_gaps     = 1'b0;
  int               cur_x;
  int               cur_y;
  int               cur_z;
  logic [31:0]      stall_pat   = '1;
  logic [7:0]       stall_cnt   = '0;

  three_axis_motion_change_detector_top u_dut (.*);

  always #5 clk_i = ~clk_i;

  // receiver: rotating ready pattern, reloaded whenever stall_cnt wraps; bit 0
  // kept set so every turn of the pattern holds at least one ready bit
  always @(posedge clk_i) begin
    stall_cnt <= stall_cnt + 8'd1;
    if (stall_cnt == 8'd0) begin
      stall_pat <= ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'h1);
    end else begin
      stall_pat <= {stall_pat[0], stall_pat[31:1]};
    end
    m_axis_tready <= stall_pat[0];
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_sample(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic sample_t mk_sample(int x, int y, int z);
    sample_t s;
    s.x_word = {x[COUNT_W-1:0], 4'($urandom_range(0, 15))};
    s.y_word = {y[COUNT_W-1:0], 4'($urandom_range(0, 15))};
    s.z_word = {z[COUNT_W-1:0], 4'($urandom_range(0, 15))};
    return s;
  endfunction

  function automatic int jitter(int c, int span);
    int v;
    v = c + int'($urandom_range(0, 2 * span)) - span;
    if (v > 2047) v = 2047;
    else if (v < -2048) v = -2048;
    return v;
  endfunction

  // mostly small moves around a drifting point, one axis pushed harder so
  // all three event kinds show up; some repeats and some raw noise
  function automatic sample_t next_random_sample();
    int      mode;
    int      span;
    int      big;
    sample_t s;
    mode = $urandom_range(0, 19);
    span = int'(sb.threshold) * 3 / 2 + 4;
    big  = $urandom_range(0, 2);
    if (mode < 3) begin
      s.x_word = 16'($urandom);
      s.y_word = 16'($urandom);
      s.z_word = 16'($urandom);
      return s;
    end
    if (mode >= 5) begin
      cur_x = jitter(cur_x, (big == 0) ? span : span / 3);
      cur_y = jitter(cur_y, (big == 1) ? span : span / 3);
      cur_z = jitter(cur_z, (big == 2) ? span : span / 3);
    end
    return mk_sample(cur_x, cur_y, cur_z);
  endfunction

  task automatic send_sample(input sample_t s);
    if (burst_left == 0) begin
      if (!no_gaps) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
  endtask

  // drain everything in flight, then write both registers; the first edge
  // lets the last accepted word reach the scoreboard
  task automatic reconfigure(input logic [COUNT_W-1:0] thr,
                             input logic [CFG_DATA_W-1:0] hold_raw);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= REG_THRESHOLD;
    cfg_wdata_i <= thr;
    @(posedge clk_i);
    cfg_addr_i  <= REG_HOLDOFF;
    cfg_wdata_i <= hold_raw;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_config(thr, hold_raw[HOLDOFF_W-1:0]);
    no_gaps = ($urandom_range(0, 3) == 0);
  endtask

  initial begin
    logic [COUNT_W-1:0]    thr;
    logic [HOLDOFF_W-1:0]  hold;
    int                    pick;
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: priming sample at the extremes, then moves one short
    send_sample(mk_sample(-2048, 2047, 0));
    send_sample(mk_sample(-1741, 2047, 0));
    send_sample(mk_sample(-1741, 1740, 307));

    // upper bits of the holdoff write must be dropped
    reconfigure(12'd100, 12'hF02);
    send_sample(mk_sample(-1641, 1740, 307));   // X
    send_sample(mk_sample(2047, -2048, 0));     // held off
    send_sample(mk_sample(2047, -2048, 0));     // held off
    send_sample(mk_sample(-1641, 1641, 307));   // vs triggering sample: none
    send_sample(mk_sample(-1641, 1741, 207));   // Y wins over Z
    send_sample(mk_sample(0, 0, 0));
    send_sample(mk_sample(0, 0, 0));
    send_sample(mk_sample(-1641, 1741, 307));   // Z
    send_sample(mk_sample(0, 0, 0));
    send_sample(mk_sample(0, 0, 0));
    send_sample(mk_sample(2047, 2047, 2047));   // X
    send_sample(mk_sample(0, 0, 0));
    send_sample(mk_sample(0, 0, 0));

    // full-scale threshold, no holdoff
    reconfigure(12'd4095, 12'd0);
    send_sample(mk_sample(-2048, 2047, 2047));
    send_sample(mk_sample(2047, 2047, 2047));
    send_sample(mk_sample(2046, -2048, 2047));

    // zero threshold: every sample is an X event
    reconfigure(12'd0, 12'd0);
    send_sample(mk_sample(2046, -2048, 2047));
    send_sample(mk_sample(2046, -2048, 2047));

    cur_x = 2046;
    cur_y = -2048;
    cur_z = 2047;
    for (int p = 0; p < 16; p++) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0:       thr = 12'd0;
        1:       thr = 12'd4095;
        2:       thr = THRESHOLD_RST;
        3, 4, 5: thr = 12'($urandom_range(1, 4095));
        default: thr = 12'($urandom_range(20, 400));
      endcase
      pick = $urandom_range(0, 9);
      if (p == 0 || pick == 0) hold = 8'd255;
      else if (pick == 1) hold = 8'd0;
      else if (pick == 2) hold = HOLDOFF_RST;
      else hold = 8'($urandom_range(0, 12));
      reconfigure(thr, {4'($urandom_range(0, 15)), hold});
      repeat ($urandom_range(80, 130)) send_sample(next_random_sample());
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
